// ===== src/cfc_pkg.sv =====
// Shared types, header offsets, status codes and the CRC32C byte update
// for the frame checker. No dependencies.
`default_nettype none

package cfc_pkg;

  localparam int unsigned CountW   = 33;
  localparam int unsigned HdrSize  = 14;
  localparam int unsigned OffType  = 4;
  localparam int unsigned OffFlags = 5;
  localparam int unsigned OffLen   = 6;
  localparam int unsigned OffCrc   = 10;

  localparam logic [31:0] CrcPoly = 32'h82F6_3B78;
  localparam logic [31:0] CrcInit = 32'hFFFF_FFFF;

  typedef enum logic [2:0] {
    STATUS_OK        = 3'd0,
    STATUS_SHORT     = 3'd1,
    STATUS_BAD_MAGIC = 3'd2,
    STATUS_LEN_ERR   = 3'd3,
    STATUS_CRC_ERR   = 3'd4
  } status_e;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } beat_t;

  typedef struct packed {
    logic advance;
    logic clear;
  } crc_ctrl_t;

  function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b);
    logic [31:0] c;
    c = crc ^ {24'd0, b};
    for (int i = 0; i < 8; i++) begin
      c = c[0] ? ((c >> 1) ^ CrcPoly) : (c >> 1);
    end
    return c;
  endfunction

endpackage

`default_nettype wire

// ===== src/cfc_in_reg.sv =====
// Input register stage of the frame checker: holds one accepted beat until
// the processing stage takes it. Depends on cfc_pkg.
`default_nettype none

module cfc_in_reg (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid_i,
  output logic               in_stall_o,
  input  wire logic [7:0]    data_byte_i,
  input  wire logic          last_byte_i,
  input  wire logic          take_i,
  output logic               beat_valid_o,
  output cfc_pkg::beat_t     beat_o
);
  import cfc_pkg::*;

  logic  valid_q, valid_d;
  beat_t beat_q;
  logic  load;

  assign in_stall_o = valid_q && !take_i;
  assign load       = in_valid_i && !in_stall_o;

  always_comb begin
    valid_d = valid_q;
    if (load) begin
      valid_d = 1'b1;
    end else if (take_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      beat_q <= '{data: data_byte_i, last: last_byte_i};
    end
  end

  assign beat_valid_o = valid_q;
  assign beat_o       = beat_q;

endmodule

`default_nettype wire

// ===== src/cfc_crc_unit.sv =====
// Running CRC32C register with its one-byte update, restarted per frame.
// Depends on cfc_pkg.
`default_nettype none

module cfc_crc_unit (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  cfc_pkg::crc_ctrl_t ctrl_i,
  input  wire logic [7:0]    data_i,
  output logic [31:0]        crc_next_o
);
  import cfc_pkg::*;

  logic [31:0] crc_q, crc_d;

  assign crc_next_o = ctrl_i.advance ? crc_byte(crc_q, data_i) : crc_q;

  always_comb begin
    crc_d = crc_next_o;
    if (ctrl_i.clear) begin
      crc_d = CrcInit;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      crc_q <= CrcInit;
    end else begin
      crc_q <= crc_d;
    end
  end

endmodule

`default_nettype wire

// ===== src/crc32c_frame_checker.sv =====
// Top level of the CRC32C frame checker: header capture, byte count, verdict
// and result register. Depends on cfc_pkg, cfc_in_reg and cfc_crc_unit.
//
// Takes one frame byte per cycle while the output is not stalled; each
// accepted byte passes through the input register and the result register,
// and the one-byte CRC32C update and the header compares are combinational
// between the two. The first 14 bytes are the little-endian header (magic,
// type, flags, payload length, payload CRC32C) and give no result unless one
// of them is the last byte. Every later byte comes out with has_data set. The
// last byte also carries frame_end with the status (short, bad magic, length
// mismatch, CRC mismatch in that priority, else ok) and the header type and
// flags; on any status but ok the receiver drops the streamed payload. Write
// the expected magic only while the block is idle.
`default_nettype none

module crc32c_frame_checker (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [31:0] cfg_data_i,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic [7:0]  data_byte_i,
  input  wire logic        last_byte_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic             has_data_o,
  output logic [7:0]       payload_byte_o,
  output logic             frame_end_o,
  output logic [2:0]       status_o,
  output logic [7:0]       msg_type_o,
  output logic [7:0]       msg_flags_o
);
  import cfc_pkg::*;

  logic              beat_valid;
  beat_t             beat;
  logic              take;
  crc_ctrl_t         crc_ctrl;
  logic [31:0]       crc_next;

  logic [31:0]       magic_word_q;
  logic [CountW-1:0] count_q, count_d, count_inc;
  logic [31:0]       hdr_magic_q, hdr_magic_d;
  logic [7:0]        type_q, type_d;
  logic [7:0]        flags_q, flags_d;
  logic [31:0]       length_q, length_d;
  logic [31:0]       exp_crc_q, exp_crc_d;
  logic [1:0]        lane;
  logic              is_data;
  logic              emit;
  status_e           status;

  logic              out_valid_q, out_valid_d;
  logic              has_data_q;
  logic [7:0]        payload_q;
  logic              frame_end_q;
  status_e           status_q;
  logic [7:0]        msg_type_q;
  logic [7:0]        msg_flags_q;

  cfc_in_reg u_in_reg (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .data_byte_i  (data_byte_i),
    .last_byte_i  (last_byte_i),
    .take_i       (take),
    .beat_valid_o (beat_valid),
    .beat_o       (beat)
  );

  assign take = beat_valid && !(out_valid_q && out_stall_i);

  assign is_data  = (count_q >= CountW'(HdrSize));
  assign crc_ctrl = '{advance: take && is_data, clear: take && beat.last};

  cfc_crc_unit u_crc (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ctrl_i     (crc_ctrl),
    .data_i     (beat.data),
    .crc_next_o (crc_next)
  );

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      magic_word_q <= '0;
    end else if (cfg_valid_i) begin
      magic_word_q <= cfg_data_i;
    end
  end

  assign lane      = count_q[1:0] + 2'd2;
  assign count_inc = (&count_q) ? count_q : count_q + CountW'(1);

  always_comb begin
    hdr_magic_d = hdr_magic_q;
    type_d      = type_q;
    flags_d     = flags_q;
    length_d    = length_q;
    exp_crc_d   = exp_crc_q;
    if (count_q < CountW'(OffType)) begin
      hdr_magic_d[count_q[1:0]*8 +: 8] = beat.data;
    end else if (count_q == CountW'(OffType)) begin
      type_d = beat.data;
    end else if (count_q == CountW'(OffFlags)) begin
      flags_d = beat.data;
    end else if (count_q < CountW'(OffCrc)) begin
      length_d[lane*8 +: 8] = beat.data;
    end else if (count_q < CountW'(HdrSize)) begin
      exp_crc_d[lane*8 +: 8] = beat.data;
    end
  end

  always_comb begin
    if (count_inc < CountW'(HdrSize)) begin
      status = STATUS_SHORT;
    end else if (hdr_magic_d != magic_word_q) begin
      status = STATUS_BAD_MAGIC;
    end else if (count_inc != CountW'(HdrSize) + {1'b0, length_d}) begin
      status = STATUS_LEN_ERR;
    end else if (~crc_next != exp_crc_d) begin
      status = STATUS_CRC_ERR;
    end else begin
      status = STATUS_OK;
    end
  end

  assign emit = take && (beat.last || is_data);

  always_comb begin
    count_d = count_q;
    if (take) begin
      count_d = beat.last ? '0 : count_inc;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      hdr_magic_q <= '0;
      type_q      <= '0;
      flags_q     <= '0;
      length_q    <= '0;
      exp_crc_q   <= '0;
    end else begin
      count_q <= count_d;
      if (take) begin
        if (beat.last) begin
          hdr_magic_q <= '0;
          type_q      <= '0;
          flags_q     <= '0;
          length_q    <= '0;
          exp_crc_q   <= '0;
        end else begin
          hdr_magic_q <= hdr_magic_d;
          type_q      <= type_d;
          flags_q     <= flags_d;
          length_q    <= length_d;
          exp_crc_q   <= exp_crc_d;
        end
      end
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (emit) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      has_data_q  <= is_data;
      payload_q   <= is_data ? beat.data : 8'd0;
      frame_end_q <= beat.last;
      status_q    <= beat.last ? status : STATUS_OK;
      msg_type_q  <= beat.last ? type_d : 8'd0;
      msg_flags_q <= beat.last ? flags_d : 8'd0;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign has_data_o     = has_data_q;
  assign payload_byte_o = payload_q;
  assign frame_end_o    = frame_end_q;
  assign status_o       = status_q;
  assign msg_type_o     = msg_type_q;
  assign msg_flags_o    = msg_flags_q;

endmodule

`default_nettype wire

// ===== dv/tb_top.sv =====
// Self-checking testbench for crc32c_frame_checker: a directed stimulus table, then
// random frames checked against a local CRC32C deframer model, with bursty
// source and sink idling. Depends on cfc_pkg and the RTL under src/.
`default_nettype none

module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import cfc_pkg::*;

  localparam int          HdrBytes   = 14;
  localparam int          TypeAt     = 4;
  localparam int          FlagsAt    = 5;
  localparam int          LenAt      = 6;
  localparam int          CrcAt      = 10;
  localparam logic [31:0] Castagnoli = 32'h82F6_3B78;
  localparam int          DirCount   = 30;
  localparam int          PhaseCount = 8;
  localparam int          PhaseBeats = 250;
  localparam int          CycleLimit = 300000;

  typedef struct packed {
    logic       has_data;
    logic [7:0] payload;
    logic       frame_end;
    status_e    status;
    logic [7:0] msg_type;
    logic [7:0] msg_flags;
  } deframed_t;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
    logic       typed;
    deframed_t  res;
  } dir_row_t;

  localparam deframed_t NoRes = '0;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_valid = 1'b0;
  logic [31:0] cfg_data = '0;
  logic        in_valid = 1'b0;
  logic [7:0]  data_byte = '0;
  logic        last_byte = 1'b0;
  logic        out_stall = 1'b0;
  wire         cfg_ready;
  wire         in_stall;
  wire         out_valid;
  wire         has_data;
  wire  [7:0]  payload_byte;
  wire         frame_end;
  wire  [2:0]  status;
  wire  [7:0]  msg_type;
  wire  [7:0]  msg_flags;

  crc32c_frame_checker DUT (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .cfg_valid_i    (cfg_valid),
    .cfg_ready_o    (cfg_ready),
    .cfg_data_i     (cfg_data),
    .in_valid_i     (in_valid),
    .in_stall_o     (in_stall),
    .data_byte_i    (data_byte),
    .last_byte_i    (last_byte),
    .out_valid_o    (out_valid),
    .out_stall_i    (out_stall),
    .has_data_o     (has_data),
    .payload_byte_o (payload_byte),
    .frame_end_o    (frame_end),
    .status_o       (status),
    .msg_type_o     (msg_type),
    .msg_flags_o    (msg_flags)
  );

  always #5 clk = ~clk;

  // deframer state
  logic [31:0] magic_cfg;
  logic [32:0] frame_pos;
  logic [31:0] hdr_magic;
  logic [7:0]  hdr_type;
  logic [7:0]  hdr_flags;
  logic [31:0] hdr_len;
  logic [31:0] hdr_crc;
  logic [31:0] crc_acc;

  deframed_t deframed_q [$];
  dir_row_t  dir_rows [DirCount];

  int fail_count = 0;
  int cycle_count = 0;
  int beats_in = 0;
  int payload_beats = 0;
  int magic_writes = 0;
  int verdicts [8];
  int gap_pct = 0;
  int stall_pct = 0;
  int stall_run = 0;

  function automatic logic [31:0] crc32c_fold(input logic [31:0] acc, input logic [7:0] b);
    logic [31:0] x;
    x = acc ^ {24'h0, b};
    repeat (8) x = (x >> 1) ^ (Castagnoli & {32{x[0]}});
    return x;
  endfunction

  task automatic restart_frame();
    frame_pos = '0;
    hdr_magic = '0;
    hdr_type  = '0;
    hdr_flags = '0;
    hdr_len   = '0;
    hdr_crc   = '0;
    crc_acc   = '1;
  endtask

  task automatic deframe_byte(input logic [7:0] b, input logic fin, output bit got,
                              output deframed_t r);
    int idx;
    bit in_body;
    idx = (frame_pos < 33'(HdrBytes)) ? int'(frame_pos) : HdrBytes;
    in_body = 1'b0;
    r = NoRes;
    if (idx < TypeAt) hdr_magic[8*idx +: 8] = b;
    else if (idx == TypeAt) hdr_type = b;
    else if (idx == FlagsAt) hdr_flags = b;
    else if (idx < CrcAt) hdr_len[8*(idx - LenAt) +: 8] = b;
    else if (idx < HdrBytes) hdr_crc[8*(idx - CrcAt) +: 8] = b;
    else begin
      crc_acc = crc32c_fold(crc_acc, b);
      in_body = 1'b1;
    end
    if (frame_pos != '1) frame_pos++;
    got = fin || in_body;
    if (!got) return;
    r.has_data = in_body;
    r.payload  = in_body ? b : 8'h00;
    if (fin) begin
      r.frame_end = 1'b1;
      if (frame_pos < 33'(HdrBytes)) r.status = STATUS_SHORT;
      else if (hdr_magic != magic_cfg) r.status = STATUS_BAD_MAGIC;
      else if (frame_pos != 33'(HdrBytes) + {1'b0, hdr_len}) r.status = STATUS_LEN_ERR;
      else if (~crc_acc != hdr_crc) r.status = STATUS_CRC_ERR;
      else r.status = STATUS_OK;
      r.msg_type  = hdr_type;
      r.msg_flags = hdr_flags;
      restart_frame();
    end
  endtask

  task automatic send_beat(input logic [7:0] b, input logic fin, input logic typed,
                           input deframed_t typed_res);
    bit got;
    deframed_t r;
    if (gap_pct != 0 && $urandom_range(0, 99) < gap_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    in_valid  <= 1'b1;
    data_byte <= b;
    last_byte <= fin;
    do @(posedge clk); while (in_stall);
    beats_in++;
    deframe_byte(b, fin, got, r);
    if (got) deframed_q = {deframed_q, (typed ? typed_res : r)};
  endtask

  task automatic write_magic(input logic [31:0] v);
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    magic_cfg = v;
    magic_writes++;
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (deframed_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // mostly well-formed frames, some with one defect, some pure noise
  task automatic send_frame();
    logic [7:0]  fr [$];
    logic [7:0]  body [$];
    logic [31:0] mg;
    logic [31:0] len;
    logic [31:0] sum;
    int n;
    int kind;
    mg   = magic_cfg;
    n    = ($urandom_range(0, 15) == 0) ? $urandom_range(25, 200) : $urandom_range(0, 24);
    kind = $urandom_range(0, 99);
    sum  = '1;
    for (int i = 0; i < n; i++) begin
      body = {body, 8'($urandom)};
      sum = crc32c_fold(sum, body[i]);
    end
    sum = ~sum;
    len = 32'(n);
    if (kind < 10) begin
      repeat ($urandom_range(1, 40)) fr = {fr, 8'($urandom)};
    end else begin
      if (kind < 18) mg ^= 32'd1 << $urandom_range(0, 31);
      else if (kind < 24) len = $urandom_range(0, 1) ? $urandom : len + 32'd1;
      else if (kind < 30) sum ^= 32'd1 << $urandom_range(0, 31);
      for (int k = 0; k < 4; k++) fr = {fr, mg[8*k +: 8]};
      fr = {fr, 8'($urandom)};
      fr = {fr, 8'($urandom)};
      for (int k = 0; k < 4; k++) fr = {fr, len[8*k +: 8]};
      for (int k = 0; k < 4; k++) fr = {fr, sum[8*k +: 8]};
      fr = {fr, body};
      if (kind >= 30 && kind < 38) fr = fr[0:$urandom_range(0, fr.size() - 2)];
      else if (kind >= 38 && kind < 44) repeat ($urandom_range(1, 3)) fr = {fr, 8'($urandom)};
    end
    for (int i = 0; i < fr.size(); i++) send_beat(fr[i], i == fr.size() - 1, 1'b0, NoRes);
  endtask

  task automatic match_field(input string name, input logic [31:0] want, input logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin
    deframed_t want;
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("tb_top NOT OK");
      $finish;
    end
    if (out_valid && !out_stall) begin
      if (deframed_q.size() == 0) begin
        $error("result beat with nothing expected");
        fail_count++;
      end else begin
        want = deframed_q.pop_front();
        match_field("has_data", 32'(want.has_data), 32'(has_data));
        match_field("payload_byte", 32'(want.payload), 32'(payload_byte));
        match_field("frame_end", 32'(want.frame_end), 32'(frame_end));
        match_field("status", 32'(want.status), 32'(status));
        match_field("msg_type", 32'(want.msg_type), 32'(msg_type));
        match_field("msg_flags", 32'(want.msg_flags), 32'(msg_flags));
        if (frame_end === 1'b1) verdicts[status]++;
        if (has_data === 1'b1) payload_beats++;
      end
    end
    if (stall_run > 0) begin
      stall_run--;
      out_stall <= 1'b1;
    end else if (stall_pct != 0 && $urandom_range(0, 99) < stall_pct) begin
      stall_run = $urandom_range(0, 2);
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  initial begin
    logic [31:0] mg;
    magic_cfg = '0;
    restart_frame();
    dir_rows = '{
      '{8'hFF, 1'b1, 1'b1, '{1'b0, 8'h00, 1'b1, STATUS_SHORT, 8'h00, 8'h00}},
      '{8'h00, 1'b0, 1'b0, NoRes}, '{8'h00, 1'b0, 1'b0, NoRes}, '{8'h00, 1'b0, 1'b0, NoRes},
      '{8'h00, 1'b0, 1'b0, NoRes}, '{8'hFF, 1'b0, 1'b0, NoRes}, '{8'h80, 1'b0, 1'b0, NoRes},
      '{8'h00, 1'b0, 1'b0, NoRes}, '{8'h00, 1'b0, 1'b0, NoRes}, '{8'h00, 1'b0, 1'b0, NoRes},
      '{8'h00, 1'b0, 1'b0, NoRes}, '{8'h00, 1'b0, 1'b0, NoRes}, '{8'h00, 1'b0, 1'b0, NoRes},
      '{8'h00, 1'b0, 1'b0, NoRes},
      '{8'h00, 1'b1, 1'b1, '{1'b0, 8'h00, 1'b1, STATUS_OK, 8'hFF, 8'h80}},
      '{8'hFF, 1'b0, 1'b0, NoRes}, '{8'hFF, 1'b0, 1'b0, NoRes}, '{8'hFF, 1'b0, 1'b0, NoRes},
      '{8'hFF, 1'b0, 1'b0, NoRes}, '{8'h00, 1'b0, 1'b0, NoRes}, '{8'hFF, 1'b0, 1'b0, NoRes},
      '{8'hFF, 1'b0, 1'b0, NoRes}, '{8'hFF, 1'b0, 1'b0, NoRes}, '{8'hFF, 1'b0, 1'b0, NoRes},
      '{8'hFF, 1'b0, 1'b0, NoRes}, '{8'hFF, 1'b0, 1'b0, NoRes}, '{8'hFF, 1'b0, 1'b0, NoRes},
      '{8'hFF, 1'b0, 1'b0, NoRes}, '{8'hFF, 1'b0, 1'b0, NoRes},
      '{8'hFF, 1'b1, 1'b1, '{1'b1, 8'hFF, 1'b1, STATUS_BAD_MAGIC, 8'h00, 8'hFF}}
    };
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    gap_pct   = 30;
    stall_pct = 30;
    for (int i = 0; i < DirCount; i++)
      send_beat(dir_rows[i].data, dir_rows[i].last, dir_rows[i].typed, dir_rows[i].res);

    for (int p = 0; p < PhaseCount; p++) begin
      drain();
      gap_pct   = (p == PhaseCount - 1) ? 0 : 20 * $urandom_range(0, 2);
      stall_pct = (p == PhaseCount - 1) ? 0 : 20 * $urandom_range(0, 2);
      case (p)
        0:       mg = '1;
        1:       mg = '0;
        3:       mg = 32'h8000_0001;
        5:       mg = 32'h7FFF_FFFE;
        default: mg = $urandom;
      endcase
      write_magic(mg);
      while (beats_in < DirCount + (p + 1) * PhaseBeats) send_frame();
    end
    drain();
    repeat (4) @(posedge clk);

    $display("Covered %0d frame verdicts over %0d magic settings: ok %0d, short %0d,",
             verdicts[STATUS_OK] + verdicts[STATUS_SHORT] + verdicts[STATUS_BAD_MAGIC] +
             verdicts[STATUS_LEN_ERR] + verdicts[STATUS_CRC_ERR], magic_writes + 1,
             verdicts[STATUS_OK], verdicts[STATUS_SHORT]);
    $display("  bad magic %0d, length %0d, crc %0d; %0d bytes in, %0d payload bytes out",
             verdicts[STATUS_BAD_MAGIC], verdicts[STATUS_LEN_ERR], verdicts[STATUS_CRC_ERR],
             beats_in, payload_beats);
    if (fail_count == 0) begin
      $display("tb_top OK");
    end else begin
      $display("tb_top NOT OK");
    end
    $finish;
  end

endmodule

`default_nettype wire

// ===== files.f =====
src/cfc_pkg.sv
src/cfc_in_reg.sv
src/cfc_crc_unit.sv
src/crc32c_frame_checker.sv
dv/tb_top.sv
